// File: hw/rtl/aes128_block_cipher_top_defines.svh
// Assertion macros used by the cipher RTL.
// Included by the pipeline module; no other dependencies.
`ifndef AES128_BLOCK_CIPHER_TOP_DEFINES_SVH
`define AES128_BLOCK_CIPHER_TOP_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define AES_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define AES_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: hw/rtl/aes128_pkg.sv
// Types, tables and round functions for the AES-128 pipeline.
// No dependencies.
package aes128_pkg;
   localparam int NumRounds = 10;
   localparam int OpEncrypt = 0;
   localparam int OpDecrypt = 1;
   localparam int CsrKeyHigh = 0;
   localparam int CsrKeyLow = 1;

   typedef logic [7:0] byte_type;
   typedef logic [127:0] block_type;

   typedef struct packed {
      logic op;
      logic [63:0] data_high;
      logic [63:0] data_low;
   } req_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } rsp_type;

   localparam logic [2047:0] FwdBox = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

   localparam logic [2047:0] InvBox = {
      128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
      128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
      128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
      128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
      128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
      128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
      128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
      128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

   function automatic byte_type fwd_sub(input byte_type b);
      return FwdBox[2047 - 8 * b -: 8];
   endfunction

   function automatic byte_type inv_sub(input byte_type b);
      return InvBox[2047 - 8 * b -: 8];
   endfunction

   function automatic byte_type xtime(input byte_type b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte k of a block sits at bits 127-8k.
   function automatic byte_type get_byte(input block_type s, input int k);
      return s[127 - 8 * k -: 8];
   endfunction

   function automatic block_type sub_block(input block_type s, input logic inv);
      block_type o;
      for (int k = 0; k < 16; k++) begin
         o[127 - 8 * k -: 8] = inv ? inv_sub(get_byte(s, k)) : fwd_sub(get_byte(s, k));
      end
      return o;
   endfunction

   function automatic block_type rotate_rows(input block_type s, input logic left);
      block_type o;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            o[127 - 8 * (r * 4 + c) -: 8] = left ? get_byte(s, r * 4 + ((c + r) % 4))
                                               : get_byte(s, r * 4 + ((c + 4 - r) % 4));
         end
      end
      return o;
   endfunction

   function automatic block_type mix_fwd(input block_type s);
      block_type o;
      byte_type a [4];
      byte_type d [4];
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            a[i] = get_byte(s, i * 4 + c);
            d[i] = xtime(a[i]);
         end
         for (int i = 0; i < 4; i++) begin
            o[127 - 8 * (i * 4 + c) -: 8] = d[i] ^ d[(i + 1) % 4] ^ a[(i + 1) % 4]
                                           ^ a[(i + 2) % 4] ^ a[(i + 3) % 4];
         end
      end
      return o;
   endfunction

   function automatic block_type mix_inv(input block_type s);
      block_type o;
      byte_type a [4];
      byte_type x2 [4];
      byte_type x4 [4];
      byte_type x8 [4];
      byte_type m9, m11, m13, m14;
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            a[i] = get_byte(s, i * 4 + c);
            x2[i] = xtime(a[i]);
            x4[i] = xtime(x2[i]);
            x8[i] = xtime(x4[i]);
         end
         for (int i = 0; i < 4; i++) begin
            m14 = x8[i] ^ x4[i] ^ x2[i];
            m11 = x8[(i + 1) % 4] ^ x2[(i + 1) % 4] ^ a[(i + 1) % 4];
            m13 = x8[(i + 2) % 4] ^ x4[(i + 2) % 4] ^ a[(i + 2) % 4];
            m9 = x8[(i + 3) % 4] ^ a[(i + 3) % 4];
            o[127 - 8 * (i * 4 + c) -: 8] = m14 ^ m11 ^ m13 ^ m9;
         end
      end
      return o;
   endfunction

   // One key expansion step; columns of the row-major layout are key words.
   function automatic block_type next_key(input block_type p, input byte_type rc);
      block_type n;
      byte_type t [4];
      byte_type prev;
      for (int i = 0; i < 4; i++) begin
         t[i] = fwd_sub(get_byte(p, ((i + 1) % 4) * 4 + 3));
      end
      t[0] = t[0] ^ rc;
      for (int i = 0; i < 4; i++) begin
         prev = t[i];
         for (int j = 0; j < 4; j++) begin
            prev = prev ^ get_byte(p, i * 4 + j);
            n[127 - 8 * (i * 4 + j) -: 8] = prev;
         end
      end
      return n;
   endfunction
endpackage

// File: hw/rtl/aes128_key_sched.sv
// Round key schedule: registers all eleven round keys from the key registers.
// Depends on aes128_pkg.
module aes128_key_sched (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [0:0] csr_index,
   input  logic [63:0] csr_wdata,
   output aes128_pkg::block_type round_keys [aes128_pkg::NumRounds+1],
   output logic keys_ready
);
   localparam logic [3:0] SettleCycles = 4'(aes128_pkg::NumRounds + 1);
   logic [63:0] key_high_ff, key_low_ff;
   logic [3:0] settle_ff;
   aes128_pkg::block_type keys_ff [aes128_pkg::NumRounds+1];
   aes128_pkg::byte_type rcon [aes128_pkg::NumRounds];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == 1'(aes128_pkg::CsrKeyHigh)) key_high_ff <= csr_wdata;
         else key_low_ff <= csr_wdata;
      end
   end

   // The ready flag is held low after reset or a key write until the change has reached the last round key register.
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         settle_ff <= SettleCycles;
      end else if (settle_ff != 4'd0) begin
         settle_ff <= settle_ff - 4'd1;
      end
   end

   assign keys_ready = (settle_ff == 4'd0);

   always_comb begin
      rcon[0] = 8'h01;
      for (int r = 1; r < aes128_pkg::NumRounds; r++) begin
         rcon[r] = aes128_pkg::xtime(rcon[r - 1]);
      end
   end

   always_ff @(posedge clock) begin
      keys_ff[0] <= {key_high_ff, key_low_ff};
      for (int r = 1; r <= aes128_pkg::NumRounds; r++) begin
         keys_ff[r] <= aes128_pkg::next_key(keys_ff[r - 1], rcon[r - 1]);
      end
   end

   assign round_keys = keys_ff;
endmodule

// File: hw/rtl/aes128_round_pipe.sv
// Unrolled round pipeline: one register stage per round plus the initial key-add stage.
// Depends on aes128_pkg and the assertion macro header.
`include "aes128_block_cipher_top_defines.svh"
module aes128_round_pipe (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic advance,
   input  logic in_op,
   input  aes128_pkg::block_type in_block,
   input  aes128_pkg::block_type round_keys [aes128_pkg::NumRounds+1],
   output logic out_valid,
   output aes128_pkg::block_type out_block
);
   localparam int Depth = aes128_pkg::NumRounds + 1;
   logic valid_ff [Depth];
   logic op_ff [Depth];
   aes128_pkg::block_type state_ff [Depth];
   aes128_pkg::block_type state_in [Depth];

   always_comb begin
      aes128_pkg::block_type t;
      state_in[0] = in_block ^ (in_op ? round_keys[aes128_pkg::NumRounds] : round_keys[0]);
      for (int s = 1; s < Depth; s++) begin
         if (op_ff[s - 1]) begin
            t = aes128_pkg::sub_block(aes128_pkg::rotate_rows(state_ff[s - 1], 1'b0), 1'b1);
            t = t ^ round_keys[aes128_pkg::NumRounds - s];
            state_in[s] = (s < aes128_pkg::NumRounds) ? aes128_pkg::mix_inv(t) : t;
         end else begin
            t = aes128_pkg::rotate_rows(aes128_pkg::sub_block(state_ff[s - 1], 1'b0), 1'b1);
            if (s < aes128_pkg::NumRounds) t = aes128_pkg::mix_fwd(t);
            state_in[s] = t ^ round_keys[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < Depth; s++) valid_ff[s] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < Depth; s++) valid_ff[s] <= valid_ff[s - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op_ff[0] <= in_op;
         for (int s = 1; s < Depth; s++) op_ff[s] <= op_ff[s - 1];
         for (int s = 0; s < Depth; s++) state_ff[s] <= state_in[s];
      end
   end

   assign out_valid = valid_ff[Depth - 1];
   assign out_block = state_ff[Depth - 1];

   `AES_ASSERT_NXT(a_hold_valid, clock, reset, !advance && out_valid, out_valid, "stalled result lost")
   `AES_ASSERT_NXT(a_hold_data, clock, reset, !advance && out_valid, $stable(out_block), "stalled result changed")
   `AES_ASSERT_NXT(a_flow, clock, reset, advance && valid_ff[Depth - 2], out_valid, "item dropped in pipe")
endmodule

// File: hw/rtl/aes128_block_cipher_top.sv
// AES-128 cipher/inverse cipher, fully unrolled: one block per cycle, unless stalled, through eleven
// register stages, one per round plus the initial key add; a block accepted into the first
// stage is offered as a result from the last. The pipeline holds as a whole, bubbles
// included, while a result waits on a stalled result side. After reset and after each
// key write the request side stalls while the registered round keys settle. Depends on
// aes128_pkg and its submodules.
module aes128_block_cipher_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  aes128_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output aes128_pkg::rsp_type rsp_data,
   input  logic csr_we,
   input  logic [0:0] csr_index,
   input  logic [63:0] csr_wdata
);
   aes128_pkg::block_type round_keys [aes128_pkg::NumRounds+1];
   aes128_pkg::block_type out_block;
   logic advance;
   logic keys_ready;

   aes128_key_sched u_keys (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .round_keys(round_keys), .keys_ready(keys_ready)
   );

   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance || !keys_ready;

   aes128_round_pipe u_pipe (
      .clock(clock), .reset(reset), .in_valid(req_valid && keys_ready), .advance(advance),
      .in_op(req_data.op), .in_block({req_data.data_high, req_data.data_low}),
      .round_keys(round_keys), .out_valid(rsp_valid), .out_block(out_block)
   );

   assign rsp_data.result_high = out_block[127:64];
   assign rsp_data.result_low = out_block[63:0];
endmodule
